// ===== sv/qida_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// qida_pkg
// Shared types and constants for the queue ID allocator.
// -----------------------------------------------------------------------------
package qida_pkg;

  localparam int QUEUE_COUNT = 32;
  localparam int MAX_REFS    = 1024;

  localparam int KindW   = 3;
  localparam int DevW    = 3;
  localparam int QidW    = 5;
  localparam int StatusW = 3;
  localparam int RefW    = 11;

  typedef enum logic [KindW-1:0] {
    KIND_ALLOC    = 3'd0,
    KIND_FREE     = 3'd1,
    KIND_ADD_REF  = 3'd2,
    KIND_DROP_REF = 3'd3,
    KIND_READ     = 3'd4,
    KIND_CLEAR    = 3'd5
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_DEVICE = 3'd1,
    ST_NONE_FREE  = 3'd2,
    ST_AT_LIMIT   = 3'd3,
    ST_AT_ZERO    = 3'd4,
    ST_STACK_FULL = 3'd5
  } status_e;

  localparam logic [DevW-1:0] SERVED_DEVICE = '0;

  // Request beat. kind stays a raw code so unused codes pass through.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DevW-1:0]  device_id;
    logic [QidW-1:0]  queue_id;
  } req_t;

  // Result beat.
  typedef struct packed {
    status_e         status;
    logic [QidW-1:0] granted_id;
    logic [RefW-1:0] ref_count;
  } rsp_t;

  // Free-list command and status.
  typedef struct packed {
    logic pop;
    logic push;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_sts_t;

endpackage

`default_nettype wire

// ===== sv/queue_id_allocator_with_refcount.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// queue_id_allocator_with_refcount
// Hands out completion queue IDs from a free LIFO and tracks per-queue refs.
// -----------------------------------------------------------------------------
// Usage: the block never asserts busy_o, so a request beat is taken on every
// cycle that start_i is high. Each request gives exactly one result beat,
// shown on rsp_o for one cycle with done_o high. The beat passes through the
// request register, then the state update into the result register. The
// receiver cannot stall; results come out in order at up to one per cycle.
// Throughput is one request per cycle, set by the single read-modify-write
// of the free list and the count table in the work stage.
// Only device 0 is served; any other device_id is answered with bad device.
// -----------------------------------------------------------------------------
module queue_id_allocator_with_refcount
  import qida_pkg::*;
#(
  parameter int QueueCount = QUEUE_COUNT,  // 2..32, IDs are 5 bits wide
  parameter int MaxRefs    = MAX_REFS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic      busy_o,
  input  wire req_t req_i,
  output logic      done_o,
  output rsp_t      rsp_o
);

  localparam int IdW  = $clog2(QueueCount);
  localparam int CntW = $clog2(MaxRefs + 1);

  // request register
  logic vld_q;
  req_t req_q;

  // result register
  logic done_q;
  rsp_t rsp_q, rsp_d;

  // free list
  stk_cmd_t       stk_cmd;
  stk_sts_t       stk_sts;
  logic [IdW-1:0] top_id;

  // count table
  logic [IdW-1:0]  rd_idx;
  logic [CntW-1:0] rd_cnt;
  logic            wr_en;
  logic [CntW-1:0] wr_cnt;

  logic           dev_ok;
  logic           q_ok;
  logic           is_alloc;
  logic [IdW-1:0] q_idx;

  assign busy_o = 1'b0;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // -------- request register ---------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
  end

  // -------- work stage ---------------------------------------------------
  assign dev_ok   = (req_q.device_id == SERVED_DEVICE);
  assign q_ok     = (32'(req_q.queue_id) < 32'(QueueCount));
  assign is_alloc = (req_q.kind == KIND_ALLOC);
  assign q_idx    = IdW'(req_q.queue_id);
  // allocate reads the count of the ID it grants, everything else the named queue
  assign rd_idx   = is_alloc ? top_id : q_idx;

  always_comb begin
    stk_cmd    = '0;
    wr_en      = 1'b0;
    wr_cnt     = '0;
    rsp_d      = '{status: ST_OK, granted_id: '0, ref_count: '0};

    if (!vld_q) begin
      // nothing in flight
    end else if (!dev_ok) begin
      rsp_d.status = ST_BAD_DEVICE;
    end else if (is_alloc) begin
      if (stk_sts.empty) begin
        rsp_d.status = ST_NONE_FREE;
      end else begin
        stk_cmd.pop      = 1'b1;
        rsp_d.granted_id = QidW'(top_id);
        rsp_d.ref_count  = RefW'(rd_cnt);
      end
    end else if (!q_ok) begin
      rsp_d.status = ST_BAD_DEVICE;
    end else begin
      case (req_q.kind)
        KIND_FREE: begin
          if (stk_sts.full) begin
            rsp_d.status    = ST_STACK_FULL;
            rsp_d.ref_count = RefW'(rd_cnt);
          end else begin
            stk_cmd.push = 1'b1;
            wr_en        = 1'b1;
          end
        end
        KIND_ADD_REF: begin
          if (rd_cnt >= CntW'(MaxRefs)) begin
            rsp_d.status    = ST_AT_LIMIT;
            rsp_d.ref_count = RefW'(rd_cnt);
          end else begin
            wr_en           = 1'b1;
            wr_cnt          = rd_cnt + CntW'(1);
            rsp_d.ref_count = RefW'(wr_cnt);
          end
        end
        KIND_DROP_REF: begin
          if (rd_cnt == '0) begin
            rsp_d.status = ST_AT_ZERO;
          end else begin
            wr_en           = 1'b1;
            wr_cnt          = rd_cnt - CntW'(1);
            rsp_d.ref_count = RefW'(wr_cnt);
          end
        end
        KIND_CLEAR: begin
          wr_en = 1'b1;
        end
        default: begin
          // read, and the unused codes
          rsp_d.ref_count = RefW'(rd_cnt);
        end
      endcase
    end
  end

  qida_free_stack #(
    .QueueCount(QueueCount)
  ) u_stack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (stk_cmd),
    .push_id_i(q_idx),
    .top_id_o (top_id),
    .sts_o    (stk_sts)
  );

  qida_ref_table #(
    .QueueCount(QueueCount),
    .MaxRefs   (MaxRefs)
  ) u_refs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_idx_i(rd_idx),
    .rd_cnt_o(rd_cnt),
    .wr_en_i (wr_en),
    .wr_idx_i(q_idx),
    .wr_cnt_i(wr_cnt)
  );

  // -------- result register ----------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  // -------- checks -------------------------------------------------------
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 done_o)
    else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q |=> !done_o)
    else $error("result beat without request");

  a_bad_dev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !dev_ok |=> rsp_o.status == ST_BAD_DEVICE && rsp_o.ref_count == '0)
    else $error("foreign device not rejected");

  a_grant_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ST_OK |-> rsp_o.granted_id == '0)
    else $error("ID granted on a failed beat");

  a_stack_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stk_cmd.pop && stk_cmd.push))
    else $error("push and pop in one cycle");

endmodule

`default_nettype wire

// ===== sv/qida_free_stack.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// qida_free_stack
// LIFO of free queue IDs; after reset the top is 0, then 1, 2 and so on.
// -----------------------------------------------------------------------------
module qida_free_stack
  import qida_pkg::*;
#(
  parameter int QueueCount = QUEUE_COUNT,
  localparam int IdW  = $clog2(QueueCount),
  localparam int CntW = $clog2(QueueCount + 1)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire stk_cmd_t       cmd_i,
  input  wire logic [IdW-1:0] push_id_i,
  output logic [IdW-1:0]      top_id_o,
  output stk_sts_t            sts_o
);

  logic [IdW-1:0]  stack_q [QueueCount];
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] top_pos;

  assign top_pos     = count_q - CntW'(1);
  assign top_id_o    = stack_q[top_pos[IdW-1:0]];
  assign sts_o.empty = (count_q == '0);
  assign sts_o.full  = (count_q == CntW'(QueueCount));

  always_comb begin
    count_d = count_q;
    if (cmd_i.pop) begin
      count_d = count_q - CntW'(1);
    end else if (cmd_i.push) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntW'(QueueCount);
      for (int k = 0; k < QueueCount; k++) begin
        stack_q[k] <= IdW'(QueueCount - 1 - k);
      end
    end else begin
      count_q <= count_d;
      if (cmd_i.push && !cmd_i.pop) begin
        stack_q[count_q[IdW-1:0]] <= push_id_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/qida_ref_table.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// qida_ref_table
// Per-queue reference counts, one read and one write port.
// -----------------------------------------------------------------------------
module qida_ref_table
  import qida_pkg::*;
#(
  parameter int QueueCount = QUEUE_COUNT,
  parameter int MaxRefs    = MAX_REFS,
  localparam int IdW  = $clog2(QueueCount),
  localparam int CntW = $clog2(MaxRefs + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [IdW-1:0]  rd_idx_i,
  output logic [CntW-1:0]      rd_cnt_o,
  input  wire logic            wr_en_i,
  input  wire logic [IdW-1:0]  wr_idx_i,
  input  wire logic [CntW-1:0] wr_cnt_i
);

  logic [CntW-1:0] refs_q [QueueCount];

  assign rd_cnt_o = refs_q[rd_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QueueCount; k++) begin
        refs_q[k] <= '0;
      end
    end else if (wr_en_i) begin
      refs_q[wr_idx_i] <= wr_cnt_i;
    end
  end

endmodule

`default_nettype wire
